/* sv/cht_pkg.sv */
`timescale 1ns / 1ps

package cht_pkg;

    // Beat field widths
    localparam int REQ_W     = 2;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int BKT_OUT_W = 7;
    localparam int KEY_BYTES = KEY_W / 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // One slot of a chain
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    // One byte round of the shift-add-xor hash
    function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        return t ^ (t >> 6);
    endfunction

    // Final mix, first half
    function automatic logic [31:0] oaat_fin_a(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        return t ^ (t >> 11);
    endfunction

    // Final mix, second half
    function automatic logic [31:0] oaat_fin_b(input logic [31:0] h);
        return h + (h << 15);
    endfunction

endpackage

/* sv/cht_hash.sv */
`timescale 1ns / 1ps

module cht_hash #(
    parameter int NUM_BUCKETS = 128,
    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [BKT_W-1:0]          o_bucket
);
    import cht_pkg::*;

    // floor(2^32 / N): quotient estimate is exact or one short
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(NUM_BUCKETS));
    localparam logic [31:0] NB32  = 32'(NUM_BUCKETS);

    typedef enum logic [2:0] {
        H_IDLE, H_ROUND, H_FIN1, H_FIN2, H_MUL, H_QN, H_SUB
    } t_hstate;

    t_hstate          r_state;
    logic [KEY_W-1:0] r_key;
    logic [31:0]      r_h;
    logic [31:0]      r_q;
    logic [31:0]      r_qn;
    logic [1:0]       r_cnt;
    logic             r_done;
    logic [BKT_W-1:0] r_bucket;

    logic [64:0]      w_prod;
    logic [63:0]      w_qn;
    logic [31:0]      w_rem;
    logic [31:0]      w_rem_fix;

    // Reciprocal multiply, back-multiply, one correction step
    assign w_prod    = {32'd0, r_h} * {32'd0, RECIP};
    assign w_qn      = {32'd0, r_q} * {32'd0, NB32};
    assign w_rem     = r_h - r_qn;
    assign w_rem_fix = (w_rem >= NB32) ? (w_rem - NB32) : w_rem;

    // Sequencer: one byte round a cycle, then mix, then modulo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == H_SUB);
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_key   <= i_key;
                        r_h     <= '0;
                        r_cnt   <= '0;
                        r_state <= H_ROUND;
                    end
                end
                H_ROUND: begin
                    r_h   <= oaat_round(r_h, r_key[KEY_W-1 -: 8]);
                    r_key <= r_key << 8;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'(KEY_BYTES - 1)) begin
                        r_state <= H_FIN1;
                    end
                end
                H_FIN1: begin
                    r_h     <= oaat_fin_a(r_h);
                    r_state <= H_FIN2;
                end
                H_FIN2: begin
                    r_h     <= oaat_fin_b(r_h);
                    r_state <= H_MUL;
                end
                H_MUL: begin
                    r_q     <= w_prod[63:32];
                    r_state <= H_QN;
                end
                H_QN: begin
                    r_qn    <= w_qn[31:0];
                    r_state <= H_SUB;
                end
                H_SUB: begin
                    r_bucket <= BKT_W'(w_rem_fix);
                    r_state  <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;

    // Checks
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("hash done held longer than one cycle");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_bucket) < NB32))
        else $error("bucket index out of range");

    a_done_from_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(r_state) == H_SUB)
        else $error("hash done without modulo step");

endmodule

/* sv/chained_hash_table_top.sv */
`timescale 1ns / 1ps

// Chained hash table, one request per beat: set, get or delete on a 32-bit key.
// The key is hashed with a one-at-a-time shift-add-xor hash (one byte a cycle,
// then a final mix) and reduced modulo NUM_BUCKETS by a reciprocal multiply,
// a back-multiply and a correction step. A per-bucket valid row lives in
// one memory and the key/value slots in a second; both have registered reads.
// A get or delete compares the chain one slot per cycle. After reset the
// valid rows are cleared by a pass over all NUM_BUCKETS rows, during which
// no beat is taken. One request is handled at a time; a result waiting on
// the output does not block the next request from being accepted.
module chained_hash_table_top #(
    parameter int NUM_BUCKETS = 128,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] key, [63:32] value_in
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] value_out, [38:32] bucket, [39] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import cht_pkg::*;

    localparam int TOTAL  = NUM_BUCKETS * CHAIN_DEPTH;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CIDX_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_VROW, S_SCAN, S_DONE
    } t_state;

    // Memories
    logic [CHAIN_DEPTH-1:0] r_valid_mem [NUM_BUCKETS];
    t_slot                  r_slot_mem  [TOTAL];

    t_state                 r_state;
    logic [BKT_W-1:0]       r_clr_idx;
    logic [REQ_W-1:0]       r_req;
    logic [KEY_W-1:0]       r_key;
    logic [VAL_W-1:0]       r_val;
    logic [BKT_W-1:0]       r_bucket;
    logic [ADDR_W-1:0]      r_base;
    logic [CHAIN_DEPTH-1:0] r_vrow;
    t_slot                  r_kv;
    logic [CIDX_W-1:0]      r_cmp_idx;
    logic [STAT_W-1:0]      r_res_status;
    logic [VAL_W-1:0]       r_res_value;
    logic                   r_m_valid;
    logic [STAT_W-1:0]      r_m_status;
    logic [VAL_W-1:0]       r_m_value;
    logic [BKT_OUT_W-1:0]   r_m_bucket;

    logic                   w_accept;
    logic                   w_hash_done;
    logic [BKT_W-1:0]       w_hash_bucket;
    logic                   w_free_found;
    logic [CIDX_W-1:0]      w_free_idx;
    logic                   w_hit;
    logic                   w_last;
    logic                   w_vm_we;
    logic [BKT_W-1:0]       w_vm_waddr;
    logic [CHAIN_DEPTH-1:0] w_vm_wdata;
    logic                   w_vm_re;
    logic [BKT_W-1:0]       w_vm_raddr;
    logic                   w_kv_we;
    logic [ADDR_W-1:0]      w_kv_waddr;
    t_slot                  w_kv_wdata;
    logic                   w_kv_re;
    logic [ADDR_W-1:0]      w_kv_raddr;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Hash and bucket reduction
    cht_hash #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_key    (i_s_tdata[KEY_W-1:0]),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bucket)
    );

    // Lowest free slot of the bucket
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = CHAIN_DEPTH - 1; i >= 0; i--) begin
            if (!r_vrow[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = CIDX_W'(i);
            end
        end
    end

    assign w_hit  = r_vrow[r_cmp_idx] && (r_kv.key == r_key);
    assign w_last = (r_cmp_idx == CIDX_W'(CHAIN_DEPTH - 1));

    // Memory port control
    always_comb begin
        w_vm_we    = 1'b0;
        w_vm_waddr = r_bucket;
        w_vm_wdata = r_vrow;
        w_vm_re    = 1'b0;
        w_vm_raddr = w_hash_bucket;
        w_kv_we    = 1'b0;
        w_kv_waddr = r_base + ADDR_W'(w_free_idx);
        w_kv_wdata = '{key: r_key, value: r_val};
        w_kv_re    = 1'b0;
        w_kv_raddr = r_base;
        case (r_state)
            S_CLEAR: begin
                w_vm_we    = 1'b1;
                w_vm_waddr = r_clr_idx;
                w_vm_wdata = '0;
            end
            S_HASH: begin
                w_vm_re = w_hash_done;
            end
            S_VROW: begin
                if (r_req == REQ_SET && w_free_found) begin
                    w_kv_we                = 1'b1;
                    w_vm_we                = 1'b1;
                    w_vm_wdata[w_free_idx] = 1'b1;
                end
                if (r_req == REQ_GET || r_req == REQ_DEL) begin
                    w_kv_re = 1'b1;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    if (r_req == REQ_DEL) begin
                        w_vm_we               = 1'b1;
                        w_vm_wdata[r_cmp_idx] = 1'b0;
                    end
                end else if (!w_last) begin
                    w_kv_re    = 1'b1;
                    w_kv_raddr = r_base + ADDR_W'(r_cmp_idx) + ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Valid rows, one per bucket
    always_ff @(posedge i_clk) begin
        if (w_vm_we) begin
            r_valid_mem[w_vm_waddr] <= w_vm_wdata;
        end
        if (w_vm_re) begin
            r_vrow <= r_valid_mem[w_vm_raddr];
        end
    end

    // Key/value slots
    always_ff @(posedge i_clk) begin
        if (w_kv_we) begin
            r_slot_mem[w_kv_waddr] <= w_kv_wdata;
        end
        if (w_kv_re) begin
            r_kv <= r_slot_mem[w_kv_raddr];
        end
    end

    // Request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + BKT_W'(1);
                    if (r_clr_idx == BKT_W'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req   <= i_s_tuser;
                        r_key   <= i_s_tdata[KEY_W-1:0];
                        r_val   <= i_s_tdata[KEY_W +: VAL_W];
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_bucket <= w_hash_bucket;
                        r_base   <= ADDR_W'(32'(w_hash_bucket) * 32'(CHAIN_DEPTH));
                        r_state  <= S_VROW;
                    end
                end
                S_VROW: begin
                    r_res_value <= '0;
                    r_cmp_idx   <= '0;
                    case (r_req)
                        REQ_SET: begin
                            r_res_status <= w_free_found ? ST_OK : ST_FULL;
                            r_state      <= S_DONE;
                        end
                        REQ_GET, REQ_DEL: begin
                            r_state <= S_SCAN;
                        end
                        default: begin
                            r_res_status <= ST_NOT_FOUND;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_res_status <= ST_OK;
                        r_res_value  <= r_kv.value;
                        r_state      <= S_DONE;
                    end else if (w_last) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_value  <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_cmp_idx <= r_cmp_idx + CIDX_W'(1);
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_res_status;
                        r_m_value  <= r_res_value;
                        r_m_bucket <= BKT_OUT_W'(r_bucket);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_bucket, r_m_value};
    assign o_m_tuser  = r_m_status;

    // Checks
    a_hash_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> r_state == S_HASH)
        else $error("hash result arrived outside hash wait");

    a_slot_write_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kv_we |-> (r_req == REQ_SET && r_state == S_VROW))
        else $error("slot written by a request other than set");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result raised without a finished request");

    a_scan_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cmp_idx <= CIDX_W'(CHAIN_DEPTH - 1))
        else $error("chain scan ran past the last slot");

endmodule
